>>> sv/r2fft_pkg.sv
// Shared types, constants and twiddle functions of the radix-2 FFT.
`default_nettype none
package r2fft_pkg;

	localparam int MaxPoints = 64;
	localparam int AddrW     = $clog2(MaxPoints);
	localparam int SampW     = 16;
	localparam int ValW      = 23;
	localparam int TwW       = 19;
	localparam int ProdW     = ValW + TwW;
	localparam int CmbW      = ProdW + 1;
	localparam int FracW     = 17;
	localparam int RndW      = CmbW - FracW;
	localparam int SumW      = RndW + 1;
	localparam int WordW     = 2 * ValW;
	localparam int InDataW   = 2 * SampW;
	localparam int OutDataW  = ((WordW + 7) / 8) * 8;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 3;
	localparam int LogW      = 3;
	localparam int BflyW     = AddrW - 1;
	localparam int CntW      = AddrW + 1;

	localparam logic [CfgIdxW-1:0] CfgInverse = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgLog2    = 1'd1;

	typedef logic signed [ValW-1:0] val_t;
	typedef logic signed [TwW-1:0]  tw_val_t;

	typedef struct packed {
		val_t im;
		val_t re;
	} cplx_t;

	typedef struct packed {
		tw_val_t wi;
		tw_val_t wr;
	} tw_t;

	typedef struct packed {
		logic             valid;
		logic [AddrW-1:0] addr_p;
		logic [AddrW-1:0] addr_q;
		tw_t              tw;
	} bfly_req_t;

	typedef struct packed {
		logic             en;
		logic [AddrW-1:0] addr;
		cplx_t            data;
	} bfly_wr_t;

	// Length code 0 runs as 1, 7 as 6.
	function automatic logic [LogW-1:0] act_log2(input logic [LogW-1:0] lp);
		logic [LogW-1:0] r;
		r = lp;
		if (lp == 3'd0)
			r = 3'd1;
		else if (lp == 3'd7)
			r = 3'd6;
		return r;
	endfunction

	function automatic logic [AddrW-1:0] bitrev(input logic [AddrW-1:0] idx,
			input logic [LogW-1:0] lp);
		logic [AddrW-1:0] r;
		for (int b = 0; b < AddrW; b++)
			r[AddrW-1-b] = idx[b];
		return r >> (3'(AddrW) - lp);
	endfunction

	// Quarter-wave cosine in Q1.17, angle 2*pi*k/64.
	function automatic logic [FracW:0] cos_rom(input logic [4:0] k);
		logic [FracW:0] c;
		case (k)
			5'd0:    c = 18'd131072;
			5'd1:    c = 18'd130441;
			5'd2:    c = 18'd128553;
			5'd3:    c = 18'd125428;
			5'd4:    c = 18'd121095;
			5'd5:    c = 18'd115595;
			5'd6:    c = 18'd108982;
			5'd7:    c = 18'd101320;
			5'd8:    c = 18'd92682;
			5'd9:    c = 18'd83151;
			5'd10:   c = 18'd72820;
			5'd11:   c = 18'd61787;
			5'd12:   c = 18'd50159;
			5'd13:   c = 18'd38048;
			5'd14:   c = 18'd25571;
			5'd15:   c = 18'd12847;
			default: c = 18'd0;
		endcase
		return c;
	endfunction

	// Twiddle for k in 0..31; the sine sign follows the direction.
	function automatic tw_t twiddle(input logic [4:0] k, input logic inv);
		tw_val_t c;
		tw_val_t s;
		tw_t     t;
		if (k <= 5'd16) begin
			c = $signed({1'b0, cos_rom(k)});
			s = $signed({1'b0, cos_rom(5'd16 - k)});
		end else begin
			c = -$signed({1'b0, cos_rom(5'(6'd32 - {1'b0, k}))});
			s = $signed({1'b0, cos_rom(k - 5'd16)});
		end
		t.wr = c;
		t.wi = inv ? s : -s;
		return t;
	endfunction

	function automatic val_t sat_val(input logic signed [SumW-1:0] x);
		val_t r;
		if (x > $signed(SumW'(4194303)))
			r = 23'sd4194303;
		else if (x < -$signed(SumW'(4194304)))
			r = -23'sd4194304;
		else
			r = x[ValW-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/r2fft_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module r2fft_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr0,
	input  wire logic [$clog2(D)-1:0] raddr1,
	output logic      [W-1:0]         rdata0,
	output logic      [W-1:0]         rdata1
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule
`default_nettype wire

>>> sv/r2fft_bfly.sv
// Pipelined radix-2 butterfly: multiply, round, add/subtract, write back.
`default_nettype none
module r2fft_bfly (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire r2fft_pkg::bfly_req_t req,
	input  wire r2fft_pkg::cplx_t     rd_p,
	input  wire r2fft_pkg::cplx_t     rd_q,
	output r2fft_pkg::bfly_wr_t       wr,
	output logic                      busy
);

	logic                            valid_s1, valid_s2, valid_s3, valid_s4;
	logic [r2fft_pkg::AddrW-1:0]     addr_p_s1, addr_q_s1;
	logic [r2fft_pkg::AddrW-1:0]     addr_p_s2, addr_q_s2;
	logic [r2fft_pkg::AddrW-1:0]     addr_p_s3, addr_q_s3, addr_q_s4;
	r2fft_pkg::tw_t                  tw_s1;
	r2fft_pkg::cplx_t                u_s2, u_s3, q_out_s4;
	logic signed [r2fft_pkg::ProdW-1:0] prr, pii, pri, pir;
	logic signed [r2fft_pkg::ProdW-1:0] prr_s2, pii_s2, pri_s2, pir_s2;
	logic signed [r2fft_pkg::CmbW-1:0]  cmb_re, cmb_im;
	logic signed [r2fft_pkg::RndW-1:0]  v_re_s3, v_im_s3;
	logic signed [r2fft_pkg::SumW-1:0]  sum_re, sum_im, dif_re, dif_im;
	r2fft_pkg::cplx_t                p_out, q_out;

	// Complex product of the lower leg with the twiddle.
	assign prr = $signed(rd_q.re) * $signed(tw_s1.wr);
	assign pii = $signed(rd_q.im) * $signed(tw_s1.wi);
	assign pri = $signed(rd_q.re) * $signed(tw_s1.wi);
	assign pir = $signed(rd_q.im) * $signed(tw_s1.wr);

	// Round to nearest, ties up: add half an LSB, keep the upper bits.
	assign cmb_re = $signed({prr_s2[r2fft_pkg::ProdW-1], prr_s2})
		- $signed({pii_s2[r2fft_pkg::ProdW-1], pii_s2})
		+ $signed(r2fft_pkg::CmbW'(65536));
	assign cmb_im = $signed({pri_s2[r2fft_pkg::ProdW-1], pri_s2})
		+ $signed({pir_s2[r2fft_pkg::ProdW-1], pir_s2})
		+ $signed(r2fft_pkg::CmbW'(65536));

	assign sum_re = $signed(u_s3.re) + v_re_s3;
	assign sum_im = $signed(u_s3.im) + v_im_s3;
	assign dif_re = $signed(u_s3.re) - v_re_s3;
	assign dif_im = $signed(u_s3.im) - v_im_s3;

	always_comb begin
		p_out.re = r2fft_pkg::sat_val(sum_re);
		p_out.im = r2fft_pkg::sat_val(sum_im);
		q_out.re = r2fft_pkg::sat_val(dif_re);
		q_out.im = r2fft_pkg::sat_val(dif_im);
	end

	// Upper leg writes first, lower leg in the next cycle.
	always_comb begin
		wr.en   = valid_s3 | valid_s4;
		wr.addr = valid_s3 ? addr_p_s3 : addr_q_s4;
		wr.data = valid_s3 ? p_out : q_out_s4;
	end

	assign busy = valid_s1 | valid_s2 | valid_s3 | valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		addr_p_s1 <= req.addr_p;
		addr_q_s1 <= req.addr_q;
		tw_s1     <= req.tw;
		addr_p_s2 <= addr_p_s1;
		addr_q_s2 <= addr_q_s1;
		u_s2      <= rd_p;
		prr_s2    <= prr;
		pii_s2    <= pii;
		pri_s2    <= pri;
		pir_s2    <= pir;
		addr_p_s3 <= addr_p_s2;
		addr_q_s3 <= addr_q_s2;
		u_s3      <= u_s2;
		v_re_s3   <= cmb_re[r2fft_pkg::CmbW-1:r2fft_pkg::FracW];
		v_im_s3   <= cmb_im[r2fft_pkg::CmbW-1:r2fft_pkg::FracW];
		addr_q_s4 <= addr_q_s3;
		q_out_s4  <= q_out;
	end

endmodule
`default_nettype wire

>>> sv/radix2_complex_fft.sv
// Top level of the radix-2 decimation-in-time complex FFT.
//
// Usage: write inverse (index 0) and log2_points (index 1) on the cfg channel
// while the block is between frames; cfg_ready is always high. Feed N =
// 2^log2_points samples on s_axis, one beat each ({im, re}, Q1.15). The
// block takes one sample per cycle while it loads (s_axis_tready high).
// After the last sample it drops s_axis_tready, reads the load memory in
// bit-reversed order into the work memory through the first butterfly
// stage, runs the remaining stages in place, then sends N bins in natural
// order on m_axis, tlast on bin N-1. One butterfly unit is shared by all
// stages and issues a new butterfly while earlier ones are in flight, but
// only when phase_q is low, paced by the single write port of the work
// memory; each stage issues N/2 butterflies, then drains until the
// butterfly unit is idle before the next stage. Output bins leave at one
// per cycle from the read register of the work memory; when the receiver
// stalls the read address holds and the bin stays on m_axis_tdata. Reset
// returns to loading with an empty frame, inverse = 0 and log2_points = 6.
`default_nettype none
module radix2_complex_fft (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [15:0] sample_re, [31:16] sample_im
	input  wire logic [r2fft_pkg::InDataW-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [22:0] bin_re, [45:23] bin_im, [47:46] zero
	output logic      [r2fft_pkg::OutDataW-1:0]   m_axis_tdata,
	output logic                                  m_axis_tlast,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [r2fft_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [r2fft_pkg::CfgDataW-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BFLY,
		ST_DRAIN,
		ST_PRIME,
		ST_OUT
	} state_t;

	state_t                          state_q;
	logic [r2fft_pkg::CntW-1:0]      load_cnt_q;
	logic [r2fft_pkg::LogW-1:0]      stage_q;
	logic [r2fft_pkg::BflyW-1:0]     bfly_q;
	logic                            phase_q;
	logic [r2fft_pkg::AddrW-1:0]     out_idx_q;
	logic                            inverse_q;
	logic [r2fft_pkg::LogW-1:0]      log2_q;

	logic [r2fft_pkg::LogW-1:0]      lp;
	logic [r2fft_pkg::CntW-1:0]      n_pts;
	logic [r2fft_pkg::CntW-1:0]      load_next;
	logic [r2fft_pkg::BflyW-1:0]     bfly_last;
	logic [r2fft_pkg::AddrW-1:0]     out_last;
	logic [r2fft_pkg::AddrW-1:0]     mask, b_ext, p_addr, q_addr, out_addr;
	logic [4:0]                      tw_k;
	logic                            in_beat, out_beat, busy;
	r2fft_pkg::bfly_req_t            req;
	r2fft_pkg::bfly_wr_t             bwr;
	r2fft_pkg::cplx_t                ld_word;
	r2fft_pkg::cplx_t                a_rd0, a_rd1, b_rd0, b_rd1, rd_p;
	logic [r2fft_pkg::AddrW-1:0]     b_raddr0;
	logic signed [r2fft_pkg::ValW:0] scl_re, scl_im;
	r2fft_pkg::val_t                 bin_re, bin_im;

	assign lp        = r2fft_pkg::act_log2(log2_q);
	assign n_pts     = r2fft_pkg::CntW'(1) << lp;
	assign load_next = load_cnt_q + 1'b1;
	assign bfly_last = r2fft_pkg::BflyW'((n_pts >> 1) - 1'b1);
	assign out_last  = r2fft_pkg::AddrW'(n_pts - 1'b1);

	assign in_beat  = s_axis_tvalid & s_axis_tready;
	assign out_beat = m_axis_tvalid & m_axis_tready;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign cfg_ready     = 1'b1;

	// Butterfly pair of this stage: p and q are half a group apart.
	assign mask   = (r2fft_pkg::AddrW'(1) << (stage_q - 1'b1)) - 1'b1;
	assign b_ext  = {1'b0, bfly_q};
	assign p_addr = ((b_ext & ~mask) << 1) | (b_ext & mask);
	assign q_addr = p_addr | (mask + 1'b1);
	assign tw_k   = 5'((b_ext & mask) << (3'(r2fft_pkg::AddrW) - stage_q));

	always_comb begin
		req.valid  = (state_q == ST_BFLY) && !phase_q;
		req.addr_p = p_addr;
		req.addr_q = q_addr;
		req.tw     = r2fft_pkg::twiddle(tw_k, inverse_q);
	end

	// Stage one reads the load memory in bit-reversed order.
	assign rd_p = (stage_q == 3'd1) ? a_rd0 : b_rd0;

	always_comb begin
		ld_word.re = {{(r2fft_pkg::ValW - r2fft_pkg::SampW){s_axis_tdata[15]}},
			s_axis_tdata[15:0]};
		ld_word.im = {{(r2fft_pkg::ValW - r2fft_pkg::SampW){s_axis_tdata[31]}},
			s_axis_tdata[31:16]};
	end

	r2fft_ram #(.W(r2fft_pkg::WordW), .D(r2fft_pkg::MaxPoints)) u_load_ram (
		.clk    (clk),
		.we     (in_beat),
		.waddr  (load_cnt_q[r2fft_pkg::AddrW-1:0]),
		.wdata  (ld_word),
		.raddr0 (r2fft_pkg::bitrev(p_addr, lp)),
		.raddr1 (r2fft_pkg::bitrev(q_addr, lp)),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	// Advance the read address on an accepted beat so the next bin is ready.
	assign out_addr = out_beat ? out_idx_q + 1'b1 : out_idx_q;
	assign b_raddr0 = (state_q == ST_PRIME || state_q == ST_OUT) ? out_addr : p_addr;

	r2fft_ram #(.W(r2fft_pkg::WordW), .D(r2fft_pkg::MaxPoints)) u_work_ram (
		.clk    (clk),
		.we     (bwr.en),
		.waddr  (bwr.addr),
		.wdata  (bwr.data),
		.raddr0 (b_raddr0),
		.raddr1 (q_addr),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	r2fft_bfly u_bfly (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_p   (rd_p),
		.rd_q   ((stage_q == 3'd1) ? a_rd1 : b_rd1),
		.wr     (bwr),
		.busy   (busy)
	);

	// Inverse: divide by N with a rounding arithmetic shift.
	assign scl_re = ($signed({b_rd0.re[r2fft_pkg::ValW-1], b_rd0.re})
		+ $signed((r2fft_pkg::ValW+1)'(1) << (lp - 1'b1))) >>> lp;
	assign scl_im = ($signed({b_rd0.im[r2fft_pkg::ValW-1], b_rd0.im})
		+ $signed((r2fft_pkg::ValW+1)'(1) << (lp - 1'b1))) >>> lp;
	assign bin_re = inverse_q ? scl_re[r2fft_pkg::ValW-1:0] : b_rd0.re;
	assign bin_im = inverse_q ? scl_im[r2fft_pkg::ValW-1:0] : b_rd0.im;

	assign m_axis_tdata = {{(r2fft_pkg::OutDataW - r2fft_pkg::WordW){1'b0}}, bin_im, bin_re};
	assign m_axis_tlast = (out_idx_q == out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
			log2_q    <= 3'd6;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				r2fft_pkg::CfgInverse: inverse_q <= cfg_data[0];
				r2fft_pkg::CfgLog2:    log2_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			stage_q    <= 3'd1;
			bfly_q     <= '0;
			phase_q    <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						if (load_next >= n_pts) begin
							load_cnt_q <= '0;
							stage_q    <= 3'd1;
							bfly_q     <= '0;
							phase_q    <= 1'b0;
							state_q    <= ST_BFLY;
						end else begin
							load_cnt_q <= load_next;
						end
					end
				end
				ST_BFLY: begin
					phase_q <= !phase_q;
					if (!phase_q) begin
						if (bfly_q == bfly_last) begin
							bfly_q  <= '0;
							state_q <= ST_DRAIN;
						end else begin
							bfly_q <= bfly_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					// Hold until every write of this stage has landed.
					if (!busy) begin
						phase_q <= 1'b0;
						if (stage_q == lp) begin
							out_idx_q <= '0;
							state_q   <= ST_PRIME;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= ST_BFLY;
						end
					end
				end
				ST_PRIME: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_beat) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == out_last) begin
							stage_q <= 3'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/r2fft_chk.sv
// Port-level checker for the radix-2 FFT, bound to the top level.
`default_nettype none
module r2fft_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic [r2fft_pkg::InDataW-1:0]    s_axis_tdata,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [r2fft_pkg::OutDataW-1:0]   m_axis_tdata,
	input wire logic                             m_axis_tlast,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready,
	input wire logic [r2fft_pkg::CfgIdxW-1:0]    cfg_index,
	input wire logic [r2fft_pkg::CfgDataW-1:0]   cfg_data
);

	// A stalled bin holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output beat changed");

	// Loading and readout never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while output valid");

	// The last bin hands the block back to loading.
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
			s_axis_tready && !m_axis_tvalid)
		else $error("not ready after the last bin");

	// A frame's output starts only after input readiness has dropped.
	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !s_axis_tready && !$past(s_axis_tready))
		else $error("output began straight from loading");

endmodule

bind radix2_complex_fft r2fft_chk u_chk (.*);
`default_nettype wire
